>>> src/assert_macros.svh
// Assertion helpers shared by the RTL. Each check runs on the rising clock
// edge and is suspended while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/jbe_pkg.sv
`default_nettype none
package jbe_pkg;

  localparam int NUM_COMPONENTS = 3;
  localparam int CIDX_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  localparam int TAB_W = 21;  // {length[4:0], code[15:0]}
  localparam int VAL_W = 27;  // longest code plus magnitude bits
  localparam int LEN_W = 5;
  localparam int ACC_W = 7 + VAL_W;
  localparam int CNT_W = 6;

  localparam logic [7:0] ZRL_SYMBOL = 8'hF0;
  localparam logic [7:0] EOB_SYMBOL = 8'h00;
  localparam logic [7:0] FF_BYTE = 8'hFF;
  localparam logic [7:0] STUFF_BYTE = 8'h00;
  localparam logic [4:0] DC_MAX_CAT = 5'd11;
  localparam logic [4:0] AC_MAX_CAT = 5'd10;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] RUN_16 = 6'd16;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_AC = 2'd1;
  localparam logic [1:0] ERR_DC = 2'd2;

  typedef enum logic [1:0] {
    EK_BITS  = 2'd0,
    EK_ERR   = 2'd1,
    EK_FLUSH = 2'd2
  } ekind_t;

  typedef struct packed {
    ekind_t            kind;
    logic              last;
    logic [VAL_W-1:0]  val;
    logic [LEN_W-1:0]  len;
  } entry_t;

  localparam int DC_LUMA_COUNTS [16] = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
  localparam int DC_CHROMA_COUNTS [16] = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
  localparam int AC_LUMA_COUNTS [16] = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,8'h7D};
  localparam int AC_CHROMA_COUNTS [16] = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,8'h77};

  localparam logic [7:0] AC_LUMA_SYMS [162] = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'hA1,8'h08,8'h23,8'h42,8'hB1,8'hC1,
    8'h15,8'h52,8'hD1,8'hF0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0A,8'h16,8'h17,8'h18,
    8'h19,8'h1A,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7A,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8A,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,
    8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,8'hC3,
    8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,
    8'hD9,8'hDA,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF1,8'hF2,
    8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};

  localparam logic [7:0] AC_CHROMA_SYMS [162] = '{
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'hA1,8'hB1,8'hC1,8'h09,
    8'h23,8'h33,8'h52,8'hF0,8'h15,8'h62,8'h72,8'hD1,8'h0A,8'h16,8'h24,8'h34,8'hE1,8'h25,
    8'hF1,8'h17,8'h18,8'h19,8'h1A,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8A,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,
    8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,
    8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hDA,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF2,
    8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};

  // Canonical code assignment, indexed by symbol. A symbol missing from the
  // table keeps length zero and so emits nothing.
  function automatic logic [256*TAB_W-1:0] build_ac(input logic chroma);
    logic [256*TAB_W-1:0] t;
    logic [15:0] code;
    logic [7:0] s;
    int idx;
    int n;
    t = '0;
    code = '0;
    idx = 0;
    for (int l = 1; l <= 16; l++) begin
      n = chroma ? AC_CHROMA_COUNTS[l-1] : AC_LUMA_COUNTS[l-1];
      for (int i = 0; i < n; i++) begin
        s = chroma ? AC_CHROMA_SYMS[idx] : AC_LUMA_SYMS[idx];
        t[int'(s)*TAB_W +: TAB_W] = {LEN_W'(l), code};
        idx++;
        code = code + 16'd1;
      end
      code = code << 1;
    end
    return t;
  endfunction

  function automatic logic [12*TAB_W-1:0] build_dc(input logic chroma);
    logic [12*TAB_W-1:0] t;
    logic [15:0] code;
    int idx;
    int n;
    t = '0;
    code = '0;
    idx = 0;
    for (int l = 1; l <= 16; l++) begin
      n = chroma ? DC_CHROMA_COUNTS[l-1] : DC_LUMA_COUNTS[l-1];
      for (int i = 0; i < n; i++) begin
        if (idx < 12) t[idx*TAB_W +: TAB_W] = {LEN_W'(l), code};
        idx++;
        code = code + 16'd1;
      end
      code = code << 1;
    end
    return t;
  endfunction

  localparam logic [256*TAB_W-1:0] AC_LUMA_TAB = build_ac(1'b0);
  localparam logic [256*TAB_W-1:0] AC_CHROMA_TAB = build_ac(1'b1);
  localparam logic [12*TAB_W-1:0] DC_LUMA_TAB = build_dc(1'b0);
  localparam logic [12*TAB_W-1:0] DC_CHROMA_TAB = build_dc(1'b1);

  // Number of significant bits of a magnitude.
  function automatic logic [4:0] cat_of(input logic [16:0] m);
    logic [4:0] c;
    c = '0;
    for (int b = 0; b < 17; b++) begin
      if (m[b]) c = 5'(b + 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/jbe_front.sv
`default_nettype none
module jbe_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_command,
  input  wire logic [1:0]     in_component,
  input  wire logic [5:0]     in_position,
  input  wire logic [15:0]    in_coefficient,
  output logic                q_push,
  output jbe_pkg::entry_t     q_entry,
  input  wire logic           q_ready
);
  import jbe_pkg::*;

  logic              item_v_r;
  logic              cmd_r;
  logic [1:0]        comp_r;
  logic [5:0]        pos_r;
  logic [15:0]       coef_r;
  logic [5:0]        run_r, run_nxt;
  logic [15:0]       pred_r [NUM_COMPONENTS];

  logic [CIDX_W-1:0] cidx;
  logic [15:0]       pred_cur;
  logic [16:0]       diff, dmag, acoef, amag, mval;
  logic [4:0]        dcat, acat, cat;
  logic [TAB_W-1:0]  dc_ent, ac_ent, sym_ent;
  logic [7:0]        ac_sym;
  logic [5:0]        run_inc;
  logic              comp_ok;
  logic              done;
  logic              fire;
  logic              pred_load, pred_clear;
  logic [VAL_W-1:0]  mask, mbits;

  assign cidx = comp_r[CIDX_W-1:0];
  assign comp_ok = {30'd0, comp_r} < 32'(NUM_COMPONENTS);
  assign pred_cur = comp_ok ? pred_r[cidx] : 16'd0;

  assign diff = {coef_r[15], coef_r} - {pred_cur[15], pred_cur};
  assign dmag = diff[16] ? (17'd0 - diff) : diff;
  assign dcat = cat_of(dmag);
  assign acoef = {coef_r[15], coef_r};
  assign amag = coef_r[15] ? (17'd0 - acoef) : acoef;
  assign acat = cat_of(amag);
  assign run_inc = run_r + 6'd1;

  assign dc_ent = (comp_r != 2'd0) ? DC_CHROMA_TAB[int'(dcat[3:0])*TAB_W +: TAB_W]
                                   : DC_LUMA_TAB[int'(dcat[3:0])*TAB_W +: TAB_W];

  always_comb begin
    ac_sym = {run_r[3:0], acat[3:0]};
    if (cmd_r || pos_r == 6'd0) ac_sym = EOB_SYMBOL;
    else if (coef_r == 16'd0) ac_sym = EOB_SYMBOL;
    else if (run_r >= RUN_16) ac_sym = ZRL_SYMBOL;
  end

  assign ac_ent = (comp_r != 2'd0) ? AC_CHROMA_TAB[int'(ac_sym)*TAB_W +: TAB_W]
                                   : AC_LUMA_TAB[int'(ac_sym)*TAB_W +: TAB_W];

  // Magnitude bits: negative values are sent as value minus one.
  always_comb begin
    if (pos_r == 6'd0) begin
      cat = dcat;
      mval = diff - {16'd0, diff[16]};
      sym_ent = dc_ent;
    end else begin
      cat = (coef_r == 16'd0 || run_r >= RUN_16) ? 5'd0 : acat;
      mval = acoef - {16'd0, acoef[16]};
      sym_ent = ac_ent;
    end
    mask = (VAL_W'(1) << cat) - VAL_W'(1);
    mbits = VAL_W'(mval) & mask;
  end

  always_comb begin
    q_push = 1'b0;
    q_entry.kind = EK_BITS;
    q_entry.last = 1'b1;
    q_entry.val = (VAL_W'(sym_ent[15:0]) << cat) | mbits;
    q_entry.len = sym_ent[TAB_W-1:16] + cat;
    if (item_v_r) begin
      if (cmd_r) begin
        q_push = 1'b1;
        q_entry.kind = EK_FLUSH;
      end else if (!comp_ok) begin
        q_push = 1'b0;
      end else if (pos_r == 6'd0) begin
        q_push = 1'b1;
        if (dcat > DC_MAX_CAT) begin
          q_entry.kind = EK_ERR;
          q_entry.val = VAL_W'(ERR_DC);
        end
      end else if (coef_r == 16'd0) begin
        q_push = (pos_r == LAST_POS) && (run_inc != 6'd0);
      end else if (acat > AC_MAX_CAT) begin
        q_push = 1'b1;
        q_entry.kind = EK_ERR;
        q_entry.val = VAL_W'(ERR_AC);
      end else begin
        q_push = 1'b1;
        q_entry.last = (run_r < RUN_16);
      end
    end
  end

  assign fire = q_push && q_ready;
  assign done = item_v_r && (q_push ? (fire && q_entry.last) : 1'b1);
  assign in_ready = !item_v_r || done;

  always_comb begin
    run_nxt = run_r;
    pred_load = 1'b0;
    pred_clear = 1'b0;
    if (item_v_r && cmd_r) begin
      if (done) begin
        run_nxt = 6'd0;
        pred_clear = 1'b1;
      end
    end else if (item_v_r && comp_ok) begin
      if (pos_r == 6'd0) begin
        if (done && dcat <= DC_MAX_CAT) begin
          run_nxt = 6'd0;
          pred_load = 1'b1;
        end
      end else if (coef_r == 16'd0) begin
        if (done) run_nxt = q_push ? 6'd0 : run_inc;
      end else if (acat <= AC_MAX_CAT) begin
        if (fire) run_nxt = q_entry.last ? 6'd0 : (run_r - RUN_16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      run_r <= 6'd0;
      for (int i = 0; i < NUM_COMPONENTS; i++) pred_r[i] <= 16'd0;
    end else begin
      run_r <= run_nxt;
      if (pred_clear) begin
        for (int i = 0; i < NUM_COMPONENTS; i++) pred_r[i] <= 16'd0;
      end else if (pred_load) begin
        pred_r[cidx] <= coef_r;
      end
      if (in_ready) item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r <= in_command;
      comp_r <= in_component;
      pos_r <= in_position;
      coef_r <= in_coefficient;
    end
  end

endmodule
`default_nettype wire

>>> src/jbe_fifo.sv
`default_nettype none
module jbe_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire jbe_pkg::entry_t  push_entry,
  output logic                  push_ready,
  input  wire logic             pop,
  output jbe_pkg::entry_t       pop_entry,
  output logic                  pop_valid
);
  import jbe_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != (PTR_W+1)'(DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_entry = mem_r[rd_r];
  assign do_push = push && push_ready;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + PTR_W'(1);
      if (do_pop) rd_r <= rd_r + PTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + (PTR_W+1)'(1);
      else if (!do_push && do_pop) cnt_r <= cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_entry;
  end

endmodule
`default_nettype wire

>>> src/jbe_back.sv
`default_nettype none
module jbe_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire jbe_pkg::entry_t  q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic [1:0]            out_error,
  output logic                  out_last
);
  import jbe_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             stuff_r, stuff_nxt;
  logic             end_r, end_nxt;
  logic             held_v_r;
  logic [7:0]       held_byte_r;
  logic [1:0]       held_err_r;
  logic             out_v_r;

  logic             out_free, produce_ok;
  logic             produce, release_last;
  logic [7:0]       prod_byte;
  logic [1:0]       prod_err;
  logic [7:0]       top_byte;
  logic [2:0]       pad;
  logic [ACC_W-1:0] acc_sh;

  assign out_free = !out_v_r || out_ready;
  assign produce_ok = !held_v_r || out_free;
  assign top_byte = 8'(acc_r >> (cnt_r - CNT_W'(8)));
  assign pad = 3'(CNT_W'(8) - cnt_r);
  assign acc_sh = acc_r << q_entry.len;

  // Each produced byte waits in the hold register until either a later byte
  // of the same request arrives or the request ends and it leaves as last.
  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    stuff_nxt = stuff_r;
    end_nxt = end_r;
    q_pop = 1'b0;
    produce = 1'b0;
    release_last = 1'b0;
    prod_byte = STUFF_BYTE;
    prod_err = ERR_NONE;
    if (stuff_r) begin
      if (produce_ok) begin
        produce = 1'b1;
        stuff_nxt = 1'b0;
      end
    end else if (cnt_r >= CNT_W'(8)) begin
      if (produce_ok) begin
        produce = 1'b1;
        prod_byte = top_byte;
        cnt_nxt = cnt_r - CNT_W'(8);
        stuff_nxt = (top_byte == FF_BYTE);
      end
    end else if (end_r) begin
      if (!held_v_r) begin
        end_nxt = 1'b0;
      end else if (out_free) begin
        release_last = 1'b1;
        end_nxt = 1'b0;
      end
    end else if (q_valid) begin
      case (q_entry.kind)
        EK_ERR: begin
          if (produce_ok) begin
            q_pop = 1'b1;
            produce = 1'b1;
            prod_err = q_entry.val[1:0];
            end_nxt = 1'b1;
          end
        end
        EK_FLUSH: begin
          q_pop = 1'b1;
          end_nxt = 1'b1;
          if (cnt_r != '0) begin
            acc_nxt = (acc_r << pad) | ACC_W'((8'd1 << pad) - 8'd1);
            cnt_nxt = CNT_W'(8);
          end
        end
        default: begin
          q_pop = 1'b1;
          acc_nxt = acc_sh | ACC_W'(q_entry.val);
          cnt_nxt = cnt_r + CNT_W'(q_entry.len);
          end_nxt = q_entry.last;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      stuff_r <= 1'b0;
      end_r <= 1'b0;
      held_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      stuff_r <= stuff_nxt;
      end_r <= end_nxt;
      if (produce) held_v_r <= 1'b1;
      else if (release_last) held_v_r <= 1'b0;
      if ((produce && held_v_r) || release_last) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if ((produce && held_v_r) || release_last) begin
      out_byte <= held_byte_r;
      out_error <= held_err_r;
      out_last <= release_last;
    end
    if (produce) begin
      held_byte_r <= prod_byte;
      held_err_r <= prod_err;
    end
  end

  assign out_valid = out_v_r;

endmodule
`default_nettype wire

>>> src/jpeg_baseline_entropy_coder.sv
`default_nettype none
// Baseline JPEG Huffman entropy coder.
// Input requests (in_valid/in_ready) carry a command, a component tag, a
// zig-zag position and a quantized coefficient. Command 0 codes the
// coefficient; command 1 ends the scan: the last byte is padded with ones
// and the DC predictors and zero run are cleared.
// Output requests (out_valid/out_ready) carry one scan byte each, stuffed
// zero bytes included, with out_error for a category overflow and out_last
// on the final byte caused by an input request.
// The front end takes one request per cycle while the queue has room and
// writes one bit group to a four-entry queue per cycle; a coefficient after
// sixteen or more zeros first writes one ZRL code per sixteen zeros. The back
// end packs one queue entry or sends one byte per cycle while the output
// can take it, and closes each request in a separate end step.
// A last byte is held in the hold register until the request is known to be
// complete.
// When the receiver stalls, the output register and hold stage fill, then
// the queue, then in_ready drops; nothing is lost.
// Reset (synchronous, active low) empties the queue and clears bit buffer,
// predictors and zero run.
module jpeg_baseline_entropy_coder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [1:0]  in_component,
  input  wire logic [5:0]  in_position,
  input  wire logic [15:0] in_coefficient,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_error,
  output logic             out_last
);
  import jbe_pkg::*;
  `include "assert_macros.svh"

  logic   q_push, q_ready, q_pop, q_valid;
  entry_t push_entry, pop_entry;

  jbe_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_component,
    .in_position, .in_coefficient,
    .q_push, .q_entry(push_entry), .q_ready
  );

  jbe_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_entry, .push_ready(q_ready),
    .pop(q_pop), .pop_entry, .pop_valid(q_valid)
  );

  jbe_back u_back (
    .clk, .rst_n, .q_valid, .q_entry(pop_entry), .q_pop,
    .out_valid, .out_ready, .out_byte, .out_error, .out_last
  );

  `CHK_IMPL(a_err_alone, out_valid && out_error != ERR_NONE, out_byte == 8'd0 && out_last)
  `CHK_IMPL(a_err_code, out_valid, out_error == ERR_NONE || out_error == ERR_AC || out_error == ERR_DC)
  `CHK_IMPL(a_pop_nonempty, q_pop, q_valid)
  `CHK_NEXT(a_ff_stuffed, out_valid && out_ready && out_error == ERR_NONE &&
            out_byte == FF_BYTE, !out_valid || out_byte != FF_BYTE || out_error != ERR_NONE)

endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jbe_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic [1:0] err;
    logic       last;
  } scan_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [1:0]  in_component;
  logic [5:0]  in_position;
  logic [15:0] in_coefficient;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [1:0]  out_error;
  logic        out_last;

  jpeg_baseline_entropy_coder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_component(in_component),
    .in_position(in_position), .in_coefficient(in_coefficient),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .out_error(out_error), .out_last(out_last)
  );

  // Predictor state
  logic [6:0]         pk_buf;
  int                 pk_cnt;
  logic signed [15:0] dc_pred [NUM_COMPONENTS];
  logic [5:0]         zero_run;

  scan_byte_t expected_bytes[$];
  scan_byte_t item_bytes[$];
  int         error_count;
  logic       idle_on;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic emit(input logic [7:0] b, input logic [1:0] e);
    scan_byte_t s;
    s.data = b;
    s.err = e;
    s.last = 1'b0;
    item_bytes = {item_bytes, s};
  endtask

  task automatic emit_byte(input logic [7:0] b);
    emit(b, ERR_NONE);
    if (b == FF_BYTE) emit(STUFF_BYTE, ERR_NONE);
  endtask

  task automatic put_bits(input int value, input int len);
    logic [7:0] acc;
    for (int k = len - 1; k >= 0; k--) begin
      acc = {pk_buf, value[k]};
      pk_cnt++;
      if (pk_cnt == 8) begin
        emit_byte(acc);
        pk_buf = '0;
        pk_cnt = 0;
      end else begin
        pk_buf = acc[6:0];
      end
    end
  endtask

  // Walks the canonical code assignment until the symbol is found.
  task automatic put_code(input logic chroma, input logic is_dc, input logic [7:0] sym);
    int code;
    int idx;
    int n;
    logic [7:0] s;
    code = 0;
    idx = 0;
    for (int l = 1; l <= 16; l++) begin
      if (is_dc) n = chroma ? DC_CHROMA_COUNTS[l-1] : DC_LUMA_COUNTS[l-1];
      else n = chroma ? AC_CHROMA_COUNTS[l-1] : AC_LUMA_COUNTS[l-1];
      for (int i = 0; i < n; i++) begin
        if (is_dc) s = 8'(idx);
        else s = chroma ? AC_CHROMA_SYMS[idx] : AC_LUMA_SYMS[idx];
        if (s == sym) begin
          put_bits(code, l);
          return;
        end
        idx++;
        code++;
      end
      code = code << 1;
    end
  endtask

  function automatic int category(input int v);
    int mag;
    int c;
    mag = (v < 0) ? -v : v;
    c = 0;
    while (mag != 0) begin
      c++;
      mag = mag >> 1;
    end
    return c;
  endfunction

  task automatic put_magnitude(input int v, input int cat);
    if (cat > 0) put_bits((v < 0) ? v - 1 : v, cat);
  endtask

  task automatic predict_scan_bytes(input logic cmd, input logic [1:0] comp,
                                    input logic [5:0] pos, input logic signed [15:0] coef);
    logic chroma;
    int diff;
    int cat;
    logic fault;
    chroma = (comp != 2'd0);
    fault = 1'b0;
    item_bytes.delete();
    if (cmd) begin
      if (pk_cnt != 0) emit_byte(8'(({pk_buf, 1'b1} << (7 - pk_cnt)) | ((1 << (7 - pk_cnt)) - 1)));
      pk_buf = '0;
      pk_cnt = 0;
      zero_run = '0;
      for (int i = 0; i < NUM_COMPONENTS; i++) dc_pred[i] = '0;
    end else if (comp < NUM_COMPONENTS) begin
      if (pos == 6'd0) begin
        diff = int'(coef) - int'(dc_pred[comp]);
        cat = category(diff);
        if (cat > DC_MAX_CAT) begin
          emit(8'h00, ERR_DC);
        end else begin
          dc_pred[comp] = coef;
          zero_run = '0;
          put_code(chroma, 1'b1, 8'(cat));
          put_magnitude(diff, cat);
        end
      end else begin
        if (coef == 0) begin
          zero_run = zero_run + 6'd1;
        end else begin
          cat = category(int'(coef));
          if (cat > AC_MAX_CAT) begin
            emit(8'h00, ERR_AC);
            fault = 1'b1;
          end else begin
            while (zero_run >= RUN_16) begin
              put_code(chroma, 1'b0, ZRL_SYMBOL);
              zero_run = zero_run - RUN_16;
            end
            put_code(chroma, 1'b0, {zero_run[3:0], 4'(cat)});
            put_magnitude(int'(coef), cat);
            zero_run = '0;
          end
        end
        if (!fault && pos == LAST_POS && zero_run != 0) begin
          put_code(chroma, 1'b0, EOB_SYMBOL);
          zero_run = '0;
        end
      end
    end
    if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last = 1'b1;
    expected_bytes = {expected_bytes, item_bytes};
  endtask

  task automatic send_item(input logic cmd, input logic [1:0] comp,
                           input logic [5:0] pos, input logic [15:0] coef);
    if (idle_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_component <= comp;
    in_position <= pos;
    in_coefficient <= coef;
    do @(posedge clk); while (!in_ready);
    predict_scan_bytes(cmd, comp, pos, coef);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= idle_on ? ($urandom_range(99) >= 21) : 1'b1;
  end

  always @(posedge clk) begin
    scan_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %h/%0d/%0d",
                 $time, out_byte, out_error, out_last);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
          error_count++;
        end
        if (out_error !== want.err) begin
          $display("%0t: out_error expected %0d actual %0d", $time, want.err, out_error);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %0d actual %0d", $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // A DC value near the current prediction, kept within a legal category.
  function automatic logic [15:0] dc_near(input logic [1:0] comp);
    int v;
    v = int'(dc_pred[comp]) + $urandom_range(4094) - 2047;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [15:0] ac_value();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 16'd0;
    if (r < 90) return 16'($urandom_range(14) - 7);
    if (r < 98) return 16'($urandom_range(2046) - 1023);
    return 16'($urandom_range(65535));
  endfunction

  task automatic test_dc_extremes();
    send_item(1'b0, 2'd0, 6'd0, 16'h7FFF);
    send_item(1'b0, 2'd0, 6'd0, 16'd2047);
    send_item(1'b0, 2'd0, 6'd0, 16'd0);
    send_item(1'b0, 2'd1, 6'd0, -16'sd2047);
    send_item(1'b0, 2'd2, 6'd0, 16'h8000);
    send_item(1'b0, 2'd2, 6'd0, 16'd1);
    send_item(1'b0, 2'd3, 6'd0, 16'd5);
    send_item(1'b1, 2'd3, 6'd63, 16'hFFFF);
    send_item(1'b1, 2'd0, 6'd0, 16'd0);
  endtask

  task automatic test_ac_special();
    send_item(1'b0, 2'd0, 6'd0, 16'd3);
    send_item(1'b0, 2'd0, 6'd1, 16'd1023);
    send_item(1'b0, 2'd0, 6'd2, -16'sd1023);
    send_item(1'b0, 2'd0, 6'd3, 16'd1024);
    send_item(1'b0, 2'd0, 6'd63, 16'h8000);
    for (int p = 4; p < 40; p++) send_item(1'b0, 2'd1, 6'(p), 16'd0);
    send_item(1'b0, 2'd1, 6'd40, -16'sd1);
    send_item(1'b0, 2'd2, 6'd62, 16'd0);
    send_item(1'b0, 2'd2, 6'd63, 16'd0);
    send_item(1'b0, 2'd2, 6'd63, 16'd7);
    // A run left over from an unfinished block is dropped by the next DC.
    send_item(1'b0, 2'd0, 6'd5, 16'd0);
    send_item(1'b0, 2'd0, 6'd0, 16'd9);
    // Enough out-of-order zeros to wrap the run counter.
    for (int k = 0; k < 66; k++) send_item(1'b0, 2'd0, 6'd10, 16'd0);
    send_item(1'b0, 2'd0, 6'd11, 16'd2);
    send_item(1'b1, 2'd0, 6'd0, 16'd0);
  endtask

  task automatic test_random_blocks(input int blocks);
    logic [1:0] comp;
    for (int b = 0; b < blocks; b++) begin
      comp = 2'($urandom_range(2));
      send_item(1'b0, comp, 6'd0, dc_near(comp));
      for (int p = 1; p < 64; p++) send_item(1'b0, comp, 6'(p), ac_value());
      if ($urandom_range(2) == 0) send_item(1'b1, 2'($urandom_range(3)), 6'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random_noise(input int count);
    for (int i = 0; i < count; i++)
      send_item(($urandom_range(9) == 0), 2'($urandom_range(3)), 6'($urandom_range(63)),
                ($urandom_range(1) == 0) ? 16'($urandom_range(65535)) : ac_value());
  endtask

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= 1'b0;
    in_component <= '0;
    in_position <= '0;
    in_coefficient <= '0;
    idle_on = 1'b1;
    error_count = 0;
    pk_buf = '0;
    pk_cnt = 0;
    zero_run = '0;
    for (int i = 0; i < NUM_COMPONENTS; i++) dc_pred[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_dc_extremes();
    test_ac_special();
    test_random_blocks(1);
    idle_on = 1'b0;
    test_random_blocks(1);
    idle_on = 1'b1;
    test_random_blocks(1);
    test_random_noise(30);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
